>>> hdl/assert_macros.svh
// Assertion macros used by the checker file of the collision test.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define SBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that is also checked during reset.
`define SBC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/sbc_pkg.sv
// Package of the sphere/box collision test: widths, opcodes and request types.
// Used by every module of the block; depends on nothing.
package sbc_pkg;

  localparam int COORD_BITS    = 24;
  localparam int DIR_FRAC_BITS = 14;
  localparam int NUM_AXES      = 3;
  localparam int FIELD_BITS    = 2 * COORD_BITS;
  localparam int RAD_BITS      = 23;
  localparam int DIR_BITS      = DIR_FRAC_BITS + 2;
  localparam int MAG_BITS      = COORD_BITS + 1;
  localparam int RSUM_BITS     = RAD_BITS + 1;
  localparam int SQ_BITS       = 2 * MAG_BITS;
  localparam int RSQ_BITS      = 2 * RSUM_BITS;
  localparam int S2_BITS       = SQ_BITS + 2;
  localparam int Q_BITS        = DIR_FRAC_BITS + 1;
  localparam int ACC_BITS      = S2_BITS + 2 * Q_BITS + 2;

  // Pair kinds.
  typedef enum logic [1:0] {
    OP_SS = 2'd0,
    OP_SB = 2'd1,
    OP_BS = 2'd2,
    OP_BB = 2'd3
  } op_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // One incoming request as it is taken from the ports.
  typedef struct packed {
    op_t                                op;
    logic [NUM_AXES-1:0][FIELD_BITS-1:0] a;
    logic [RAD_BITS-1:0]                 a_radius;
    logic [NUM_AXES-1:0][FIELD_BITS-1:0] b;
    logic [RAD_BITS-1:0]                 b_radius;
  } req_t;

  // Per-request data that travels beside the normalizer lanes.
  typedef struct packed {
    op_t                                 op;
    logic                                hit;
    logic [NUM_AXES-1:0]                 neg;
    logic [NUM_AXES-1:0][COORD_BITS-1:0] near;
    logic [RAD_BITS-1:0]                 rb;
  } side_t;

endpackage

>>> hdl/sbc_front.sv
// Front end of the collision test: decode, clamp, difference vector, squares
// and the hit test, over three register stages. Depends on sbc_pkg.
module sbc_front import sbc_pkg::*; (
  input  logic                              clk,
  input  logic                              en,
  input  req_t                              req,
  output side_t                             side,
  output logic [S2_BITS-1:0]                s2,
  output logic [NUM_AXES-1:0][SQ_BITS-1:0]  m2
);

  side_t                             side_a;
  logic [NUM_AXES-1:0][MAG_BITS-1:0] mag_a;
  logic [RSUM_BITS-1:0]              rad_a;

  side_t                             side1_r;
  logic [NUM_AXES-1:0][MAG_BITS-1:0] mag1_r;
  logic [RSUM_BITS-1:0]              rad1_r;

  side_t                             side2_r;
  logic [NUM_AXES-1:0][SQ_BITS-1:0]  m2_2_r;
  logic [RSQ_BITS-1:0]               rad2_2_r;

  logic [S2_BITS-1:0]                sum_b;
  side_t                             side_b;

  side_t                             side3_r;
  logic [S2_BITS-1:0]                s2_3_r;
  logic [NUM_AXES-1:0][SQ_BITS-1:0]  m2_3_r;

  // Decode each axis, clamp the centre into the box and form the difference.
  always_comb begin
    coord_t                        amin, amax, bmin, bmax, cbb, cen, lo, hi, cl;
    logic signed [COORD_BITS:0]    csum;
    logic signed [MAG_BITS-1:0]    d;
    logic                          ovl;
    side_a      = '0;
    mag_a       = '0;
    ovl         = 1'b1;
    side_a.op   = req.op;
    side_a.rb   = req.b_radius;
    for (int i = 0; i < NUM_AXES; i++) begin
      amin = coord_t'(req.a[i][COORD_BITS-1:0]);
      amax = coord_t'(req.a[i][FIELD_BITS-1:COORD_BITS]);
      bmin = coord_t'(req.b[i][COORD_BITS-1:0]);
      bmax = coord_t'(req.b[i][FIELD_BITS-1:COORD_BITS]);
      // Box centre, rounded toward minus infinity.
      csum = {amin[COORD_BITS-1], amin} + {amax[COORD_BITS-1], amax};
      cbb  = coord_t'(csum[COORD_BITS:1]);
      cen  = (req.op == OP_SB) ? amin : ((req.op == OP_BS) ? bmin : cbb);
      lo   = (req.op == OP_BS) ? amin : bmin;
      hi   = (req.op == OP_BS) ? amax : bmax;
      // Minimum first, then maximum, so an inverted box takes its maximum.
      cl   = (cen < lo) ? lo : cen;
      cl   = (cl > hi) ? hi : cl;
      if (req.op == OP_SS) begin
        side_a.near[i] = bmin;
        d = {bmin[COORD_BITS-1], bmin} - {amin[COORD_BITS-1], amin};
      end else begin
        side_a.near[i] = cl;
        d = {cl[COORD_BITS-1], cl} - {cen[COORD_BITS-1], cen};
      end
      side_a.neg[i] = d[MAG_BITS-1];
      mag_a[i]      = d[MAG_BITS-1] ? MAG_BITS'(-d) : MAG_BITS'(d);
      if ((amin > bmax) || (amax < bmin)) begin
        ovl = 1'b0;
      end
    end
    side_a.hit = ovl;
  end

  // Radius that the squared distance is measured against.
  always_comb begin
    unique case (req.op)
      OP_SS:   rad_a = {1'b0, req.a_radius} + {1'b0, req.b_radius};
      OP_SB:   rad_a = {1'b0, req.a_radius};
      default: rad_a = {1'b0, req.b_radius};
    endcase
  end

  // Stage 1 captures the request, stage 2 squares the magnitudes and radius.
  always_ff @(posedge clk) begin
    if (en) begin
      side1_r  <= side_a;
      mag1_r   <= mag_a;
      rad1_r   <= rad_a;
      side2_r  <= side1_r;
      for (int i = 0; i < NUM_AXES; i++) begin
        m2_2_r[i] <= mag1_r[i] * mag1_r[i];
      end
      rad2_2_r <= rad1_r * rad1_r;
    end
  end

  // Sum of squares and the hit decision.
  always_comb begin
    sum_b  = S2_BITS'(m2_2_r[0]) + S2_BITS'(m2_2_r[1]) + S2_BITS'(m2_2_r[2]);
    side_b = side2_r;
    if (side2_r.op != OP_BB) begin
      side_b.hit = (sum_b <= S2_BITS'(rad2_2_r));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3_r <= side_b;
      s2_3_r  <= sum_b;
      m2_3_r  <= m2_2_r;
    end
  end

  assign side = side3_r;
  assign s2   = s2_3_r;
  assign m2   = m2_3_r;

endmodule

>>> hdl/sbc_lane.sv
// One normalizer lane: rounds m * 2^F / sqrt(s2) to nearest, one result bit
// per pipeline stage, with shifts and adds only. Depends on sbc_pkg.
module sbc_lane import sbc_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [S2_BITS-1:0]   s2_i,
  input  logic [SQ_BITS-1:0]   m2_i,
  output logic [Q_BITS-1:0]    q_o
);

  localparam logic [Q_BITS-1:0] ONE = Q_BITS'(1) << DIR_FRAC_BITS;

  logic [Q_BITS-1:0]   q_r   [Q_BITS];
  logic [ACC_BITS-1:0] a_r   [Q_BITS];
  logic [ACC_BITS-1:0] b_r   [Q_BITS];
  logic [ACC_BITS-1:0] s2_r  [Q_BITS];
  logic [ACC_BITS-1:0] rhs_r [Q_BITS];

  // Each stage tries one bit t = q | 2^bit and keeps it when
  // (2t - 1)^2 * s2 <= 4 * m^2 * 2^(2F). A holds q^2 * s2 and B holds q * s2.
  for (genvar k = 0; k < Q_BITS; k++) begin : g_stage
    localparam int BIT = DIR_FRAC_BITS - k;
    logic [Q_BITS-1:0]   q_in;
    logic [ACC_BITS-1:0] a_in, b_in, s2_in, rhs_in, t_sq, t_lin, lhs;
    logic                take;

    if (k == 0) begin : g_first
      assign q_in   = '0;
      assign a_in   = '0;
      assign b_in   = '0;
      assign s2_in  = ACC_BITS'(s2_i);
      assign rhs_in = ACC_BITS'(m2_i) << (2 * DIR_FRAC_BITS + 2);
    end else begin : g_next
      assign q_in   = q_r[k-1];
      assign a_in   = a_r[k-1];
      assign b_in   = b_r[k-1];
      assign s2_in  = s2_r[k-1];
      assign rhs_in = rhs_r[k-1];
    end

    assign t_sq  = a_in + (b_in << (BIT + 1)) + (s2_in << (2 * BIT));
    assign t_lin = b_in + (s2_in << BIT);
    assign lhs   = (t_sq << 2) + s2_in - (t_lin << 2);
    // A zero vector gives a zero direction; q never grows past one.
    assign take  = (q_in != ONE) && (s2_in != '0) && (lhs <= rhs_in);

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k]   <= take ? (q_in | (Q_BITS'(1) << BIT)) : q_in;
        a_r[k]   <= take ? t_sq : a_in;
        b_r[k]   <= take ? t_lin : b_in;
        s2_r[k]  <= s2_in;
        rhs_r[k] <= rhs_in;
      end
    end
  end

  assign q_o = q_r[Q_BITS-1];

endmodule

>>> hdl/sbc_merge.sv
// Merge stage: applies signs to the lane results and forms the closest point,
// scaled by B's radius for sphere-sphere, with saturation. Depends on sbc_pkg.
module sbc_merge import sbc_pkg::*; (
  input  side_t                               side,
  input  logic [NUM_AXES-1:0][Q_BITS-1:0]     q,
  output logic                                hit,
  output logic [NUM_AXES-1:0][DIR_BITS-1:0]   dir,
  output logic [NUM_AXES-1:0][COORD_BITS-1:0] near
);

  localparam int PROD_BITS = Q_BITS + RAD_BITS;
  localparam int RND_BITS  = PROD_BITS + 1 - DIR_FRAC_BITS;
  localparam int SUM_BITS  = ((COORD_BITS > RND_BITS) ? COORD_BITS : RND_BITS) + 2;
  localparam logic signed [SUM_BITS-1:0] SAT_HI =
    SUM_BITS'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [SUM_BITS-1:0] SAT_LO = -SAT_HI - SUM_BITS'(1);
  localparam logic [PROD_BITS:0] HALF = (PROD_BITS + 1)'(1) << (DIR_FRAC_BITS - 1);

  always_comb begin
    logic [PROD_BITS-1:0]       prod;
    logic [PROD_BITS:0]         rsum;
    logic signed [SUM_BITS-1:0] rv, cv, val;
    logic [DIR_BITS-1:0]        qd;
    logic                       flip;
    hit  = side.hit;
    dir  = '0;
    near = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      // Direction sign follows the difference, inverted for box-sphere.
      flip   = side.neg[i] ^ (side.op == OP_BS);
      qd     = DIR_BITS'(q[i]);
      dir[i] = flip ? DIR_BITS'(-qd) : qd;
      // Radius offset rounded half away from zero, then saturated.
      prod = PROD_BITS'(q[i]) * PROD_BITS'(side.rb);
      rsum = {1'b0, prod} + HALF;
      rv   = SUM_BITS'(rsum[PROD_BITS:DIR_FRAC_BITS]);
      cv   = SUM_BITS'(signed'(side.near[i]));
      val  = side.neg[i] ? (cv + rv) : (cv - rv);
      if (side.op != OP_SS) begin
        near[i] = side.near[i];
      end else if (val > SAT_HI) begin
        near[i] = COORD_BITS'(SAT_HI);
      end else if (val < SAT_LO) begin
        near[i] = COORD_BITS'(SAT_LO);
      end else begin
        near[i] = COORD_BITS'(val);
      end
    end
  end

endmodule

>>> hdl/sphere_box_collision_test.sv
// Sphere / axis-aligned box collision test, one shape pair per request.
// Input channel: in_valid, in_stall and the request fields; a request is taken
// at a clock edge with in_valid high and in_stall low. Result channel:
// out_valid, out_stall and the result fields, taken the same way.
// Each request gives exactly one result, in order.
// From acceptance to out_valid a request passes three front-end stages, one
// stage per direction bit in each of the three normalizer lanes (15), and
// the output register. Throughput is one request per cycle, set by the fully
// pipelined lanes that work on x, y and z side by side.
// While a result is held by out_stall, the whole pipeline holds and in_stall
// is raised; otherwise a request is taken every cycle.
// Reset (rst_n low, synchronous) empties the pipeline and drops out_valid.
// Depends on sbc_pkg, sbc_front, sbc_lane and sbc_merge.
module sphere_box_collision_test import sbc_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_opcode,
  input  logic [FIELD_BITS-1:0]        in_a_x,
  input  logic [FIELD_BITS-1:0]        in_a_y,
  input  logic [FIELD_BITS-1:0]        in_a_z,
  input  logic [RAD_BITS-1:0]          in_a_radius,
  input  logic [FIELD_BITS-1:0]        in_b_x,
  input  logic [FIELD_BITS-1:0]        in_b_y,
  input  logic [FIELD_BITS-1:0]        in_b_z,
  input  logic [RAD_BITS-1:0]          in_b_radius,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_hit,
  output logic signed [DIR_BITS-1:0]   out_dir_x,
  output logic signed [DIR_BITS-1:0]   out_dir_y,
  output logic signed [DIR_BITS-1:0]   out_dir_z,
  output logic signed [COORD_BITS-1:0] out_near_x,
  output logic signed [COORD_BITS-1:0] out_near_y,
  output logic signed [COORD_BITS-1:0] out_near_z
);

  localparam int DEPTH = 3 + Q_BITS;

  logic                                en;
  req_t                                req;
  side_t                               side_f;
  logic [S2_BITS-1:0]                  s2_f;
  logic [NUM_AXES-1:0][SQ_BITS-1:0]    m2_f;
  logic [NUM_AXES-1:0][Q_BITS-1:0]     q_l;
  side_t                               side_dly_r [Q_BITS];
  logic [DEPTH-1:0]                    vld_r;
  logic                                hit_m;
  logic [NUM_AXES-1:0][DIR_BITS-1:0]   dir_m;
  logic [NUM_AXES-1:0][COORD_BITS-1:0] near_m;
  logic                                out_valid_r;
  logic                                hit_r;
  logic [NUM_AXES-1:0][DIR_BITS-1:0]   dir_r;
  logic [NUM_AXES-1:0][COORD_BITS-1:0] near_r;

  // The pipeline moves whenever the output register is free or being taken.
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  assign req = '{op:       op_t'(in_opcode),
                 a:        {in_a_z, in_a_y, in_a_x},
                 a_radius: in_a_radius,
                 b:        {in_b_z, in_b_y, in_b_x},
                 b_radius: in_b_radius};

  sbc_front u_front (
    .clk  (clk),
    .en   (en),
    .req  (req),
    .side (side_f),
    .s2   (s2_f),
    .m2   (m2_f)
  );

  // One normalizer lane per axis.
  for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
    sbc_lane u_lane (
      .clk  (clk),
      .en   (en),
      .s2_i (s2_f),
      .m2_i (m2_f[i]),
      .q_o  (q_l[i])
    );
  end

  // Side data delayed to line up with the lane results.
  always_ff @(posedge clk) begin
    if (en) begin
      side_dly_r[0] <= side_f;
      for (int k = 1; k < Q_BITS; k++) begin
        side_dly_r[k] <= side_dly_r[k-1];
      end
    end
  end

  sbc_merge u_merge (
    .side (side_dly_r[Q_BITS-1]),
    .q    (q_l),
    .hit  (hit_m),
    .dir  (dir_m),
    .near (near_m)
  );

  // Request valid bits and the output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[DEPTH-2:0], in_valid};
      out_valid_r <= vld_r[DEPTH-1];
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (en) begin
      hit_r  <= hit_m;
      dir_r  <= dir_m;
      near_r <= near_m;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_hit    = hit_r;
  assign out_dir_x  = dir_r[0];
  assign out_dir_y  = dir_r[1];
  assign out_dir_z  = dir_r[2];
  assign out_near_x = near_r[0];
  assign out_near_y = near_r[1];
  assign out_near_z = near_r[2];

endmodule

>>> hdl/sbc_checker.sv
// Port-level checks of the collision test and the bind that attaches them.
// Depends on sbc_pkg, assert_macros.svh and sphere_box_collision_test.
`include "assert_macros.svh"

module sbc_checker import sbc_pkg::*; (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_hit,
  input logic signed [DIR_BITS-1:0]   out_dir_x,
  input logic signed [COORD_BITS-1:0] out_near_x
);

  logic [DIR_BITS+COORD_BITS:0] held;

  // Payload bits that must not move while a result is held.
  assign held = {out_hit, out_dir_x, out_near_x};

  // A held result stays offered and unchanged.
  `SBC_ASSERT(a_hold_valid, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  `SBC_ASSERT(a_hold_data, out_valid && out_stall |=> $stable(held), "result changed while stalled")
  // The input side is only held back by a stalled result.
  `SBC_ASSERT(a_stall_src, in_stall |-> out_valid && out_stall, "input stalled without output stall")
  // Reset empties the output.
  `SBC_ASSERT_RST(a_rst_clear, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind sphere_box_collision_test sbc_checker u_sbc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_hit    (out_hit),
  .out_dir_x  (out_dir_x),
  .out_near_x (out_near_x)
);

>>> bench/tb_sphere_box_collision_test.sv
// Self-checking testbench of the sphere / axis-aligned box collision test.
// Drives directed and random shape pairs with random gaps and stalls, predicts each
// result in the bench and compares it field by field. Depends on sbc_pkg and the RTL.
`timescale 1ns / 1ps

module tb_sphere_box_collision_test;
  import sbc_pkg::*;

  localparam int LATENCY     = 19;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 60;

  typedef struct {
    logic [1:0]            op;
    logic [FIELD_BITS-1:0] a[3];
    logic [RAD_BITS-1:0]   ra;
    logic [FIELD_BITS-1:0] b[3];
    logic [RAD_BITS-1:0]   rb;
  } pair_t;

  typedef struct {
    logic                 hit;
    logic signed [15:0]   dir[3];
    logic signed [23:0]   near[3];
  } contact_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_opcode = '0;
  logic [FIELD_BITS-1:0] in_a_x = '0, in_a_y = '0, in_a_z = '0;
  logic [FIELD_BITS-1:0] in_b_x = '0, in_b_y = '0, in_b_z = '0;
  logic [RAD_BITS-1:0] in_a_radius = '0, in_b_radius = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit;
  logic signed [DIR_BITS-1:0] out_dir_x, out_dir_y, out_dir_z;
  logic signed [COORD_BITS-1:0] out_near_x, out_near_y, out_near_z;

  pair_t    pending_pairs[$];
  contact_t expected_contacts[$];
  int error_count = 0;
  int accepted_pairs = 0;
  int checked_results = 0;
  int hit_count = 0;
  int idle_cycles = 0;
  bit drain_request = 1'b0;
  bit hold_request = 1'b0;
  bit gen_done = 1'b0;

  sphere_box_collision_test DUT (.*);

  // Clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Signed coordinate held in one half of a packed field.
  function automatic longint coord_of(logic [FIELD_BITS-1:0] f, int part);
    logic signed [23:0] v;
    v = part ? f[47:24] : f[23:0];
    return longint'(v);
  endfunction

  function automatic longint clamp_axis(longint c, longint lo, longint hi);
    if (c < lo) c = lo;
    if (c > hi) c = hi;
    return c;
  endfunction

  function automatic longint saturate_coord(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  // Unit vector in Q1.14, each component rounded to nearest exactly.
  function automatic void unit_vector(input longint d[3], output longint u[3]);
    longint unsigned m[3];
    longint unsigned mx, t, o;
    logic [127:0] s2, lhs, rhs;
    int sh;
    mx = 0;
    sh = 0;
    s2 = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = d[i] < 0 ? longint'(-d[i]) : longint'(d[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      u[0] = 0; u[1] = 0; u[2] = 0;
      return;
    end
    while ((mx >> sh) > (64'd1 << 24)) sh++;
    for (int i = 0; i < 3; i++) begin
      m[i] = m[i] >> sh;
      s2 += 128'(m[i]) * 128'(m[i]);
    end
    for (int i = 0; i < 3; i++) begin
      longint unsigned q;
      q = 0;
      rhs = (128'(m[i]) * 128'(m[i])) << (2 + 2 * DIR_FRAC_BITS);
      for (int bitn = DIR_FRAC_BITS; bitn >= 0; bitn--) begin
        t = q | (64'd1 << bitn);
        o = 2 * t - 1;
        if (t > (64'd1 << DIR_FRAC_BITS)) continue;
        lhs = 128'(o * o) * s2;
        if (lhs <= rhs) q = t;
      end
      u[i] = d[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  // Expected contact of one shape pair.
  function automatic contact_t predict_contact(pair_t p);
    contact_t r;
    longint amin[3], amax[3], bmin[3], bmax[3], d[3], u[3], nr[3];
    longint c, s, rr;
    logic [127:0] dsq, rsq;
    longint unsigned rad;
    bit hit;
    for (int i = 0; i < 3; i++) begin
      amin[i] = coord_of(p.a[i], 0); amax[i] = coord_of(p.a[i], 1);
      bmin[i] = coord_of(p.b[i], 0); bmax[i] = coord_of(p.b[i], 1);
    end
    hit = 1'b1;
    if (p.op == OP_SS) begin
      for (int i = 0; i < 3; i++) d[i] = bmin[i] - amin[i];
      rad = longint'(p.ra) + longint'(p.rb);
      dsq = 0;
      for (int i = 0; i < 3; i++) dsq += 128'(d[i] * d[i]);
      rsq = 128'(rad) * 128'(rad);
      hit = dsq <= rsq;
      unit_vector(d, u);
      for (int i = 0; i < 3; i++) begin
        rr = ((u[i] < 0 ? -u[i] : u[i]) * longint'(p.rb) + (64'sd1 << 13)) >>> 14;
        if (u[i] < 0) rr = -rr;
        nr[i] = saturate_coord(bmin[i] - rr);
      end
    end else if (p.op == OP_BB) begin
      for (int i = 0; i < 3; i++) begin
        s = amin[i] + amax[i];
        c = s >>> 1;
        nr[i] = clamp_axis(c, bmin[i], bmax[i]);
        d[i] = nr[i] - c;
        if (amin[i] > bmax[i] || amax[i] < bmin[i]) hit = 1'b0;
      end
      unit_vector(d, u);
    end else begin
      dsq = 0;
      for (int i = 0; i < 3; i++) begin
        if (p.op == OP_SB) begin
          nr[i] = clamp_axis(amin[i], bmin[i], bmax[i]);
          d[i] = nr[i] - amin[i];
        end else begin
          nr[i] = clamp_axis(bmin[i], amin[i], amax[i]);
          d[i] = nr[i] - bmin[i];
        end
        dsq += 128'(d[i] * d[i]);
      end
      rad = p.op == OP_SB ? longint'(p.ra) : longint'(p.rb);
      hit = dsq <= 128'(rad) * 128'(rad);
      unit_vector(d, u);
      if (p.op == OP_BS) for (int i = 0; i < 3; i++) u[i] = -u[i];
    end
    r.hit = hit;
    for (int i = 0; i < 3; i++) begin
      r.dir[i] = 16'(u[i]);
      r.near[i] = 24'(nr[i]);
    end
    return r;
  endfunction

  function automatic logic [FIELD_BITS-1:0] pack_box(longint lo, longint hi);
    return {24'(hi), 24'(lo)};
  endfunction

  // Coordinate biased toward the extremes and toward a small working region.
  function automatic longint pick_coord();
    case ($urandom_range(0, 7))
      0: return -64'sd8388608;
      1: return 64'sd8388607;
      2: return longint'(signed'(24'($urandom())));
      default: return longint'($urandom_range(0, 32768)) - 16384;
    endcase
  endfunction

  function automatic logic [RAD_BITS-1:0] pick_radius();
    case ($urandom_range(0, 5))
      0: return '1;
      1: return '0;
      2: return RAD_BITS'($urandom());
      default: return RAD_BITS'($urandom_range(0, 20000));
    endcase
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    longint x, y;
    p.op = 2'($urandom_range(0, 3));
    p.ra = pick_radius();
    p.rb = pick_radius();
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        p.a[i] = FIELD_BITS'({$urandom(), $urandom()});
        p.b[i] = FIELD_BITS'({$urandom(), $urandom()});
      end else begin
        // Mostly well-formed boxes; sometimes inverted.
        x = pick_coord(); y = x + $urandom_range(0, 12000);
        if ($urandom_range(0, 7) == 0) y = pick_coord();
        p.a[i] = pack_box(x, y);
        x = pick_coord(); y = x + $urandom_range(0, 12000);
        if ($urandom_range(0, 7) == 0) y = pick_coord();
        p.b[i] = pack_box(x, y);
      end
    end
    return p;
  endfunction

  function automatic pair_t make_pair(logic [1:0] op, longint a0, longint a1, longint b0,
                                      longint b1, int unsigned ra, int unsigned rb);
    pair_t p;
    p.op = op;
    p.ra = RAD_BITS'(ra);
    p.rb = RAD_BITS'(rb);
    for (int i = 0; i < 3; i++) begin
      p.a[i] = pack_box(a0 + i, a1 + i);
      p.b[i] = pack_box(b0 - i, b1 - i);
    end
    return p;
  endfunction

  // Stimulus: directed corner cases, then random pairs.
  initial begin
    pair_t p;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // Separate spheres, close centres, far apart, extreme coordinates.
    pending_pairs.push_back(make_pair(OP_SS, 0, 0, 4096, 0, 2048, 2048));
    pending_pairs.push_back(make_pair(OP_SS, 100, 0, 100, 0, 5, 7));
    pending_pairs.push_back(make_pair(OP_SS, -8388608, 0, 8388607, 0, 8388607, 8388607));
    pending_pairs.push_back(make_pair(OP_SS, 8388607, 0, -8388608, 0, 0, 8388607));
    // Sphere inside box, outside box, inverted box.
    pending_pairs.push_back(make_pair(OP_SB, 0, 0, -100, 100, 0, 0));
    pending_pairs.push_back(make_pair(OP_SB, 5000, 0, -100, 100, 4000, 0));
    pending_pairs.push_back(make_pair(OP_SB, 0, 0, 100, -100, 8388607, 0));
    pending_pairs.push_back(make_pair(OP_BS, -100, 100, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(OP_BS, -100, 100, -8388608, 0, 0, 8388607));
    pending_pairs.push_back(make_pair(OP_BS, 100, -100, 300, 0, 0, 10));
    // Overlapping, separate, inverted and extreme boxes.
    pending_pairs.push_back(make_pair(OP_BB, -50, 50, 0, 200, 0, 0));
    pending_pairs.push_back(make_pair(OP_BB, -50, 50, 100, 200, 0, 0));
    pending_pairs.push_back(make_pair(OP_BB, 50, -50, -10, 10, 0, 0));
    pending_pairs.push_back(make_pair(OP_BB, -8388608, -8388607, 8388605, 8388607, 0, 0));
    pending_pairs.push_back(make_pair(OP_BB, -8388608, 8388607, -8388608, 8388607, 0, 0));
    p.op = OP_BB; p.ra = '1; p.rb = '1;
    for (int i = 0; i < 3; i++) begin p.a[i] = '1; p.b[i] = '1; end
    pending_pairs.push_back(p);
    p.op = OP_SS; p.ra = '0; p.rb = '0;
    for (int i = 0; i < 3; i++) begin p.a[i] = '0; p.b[i] = '0; end
    pending_pairs.push_back(p);
    wait (pending_pairs.size() == 0);
    // Pause until every expected result has come.
    drain_request = 1'b1;
    wait (expected_contacts.size() == 0 && !in_valid);
    drain_request = 1'b0;
    for (int n = 0; n < 1630; n++) begin
      pending_pairs.push_back(random_pair());
      if (n == 400) hold_request = 1'b1;
      if (pending_pairs.size() > 40) wait (pending_pairs.size() < 20);
    end
    gen_done = 1'b1;
  end

  // Driver: offers pending pairs with random gaps.
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_stall) begin
      // Hold the request until it is taken.
    end else if (in_valid && !in_stall) begin
      pair_t nx;
      accepted_pairs <= accepted_pairs + 1;
      expected_contacts.push_back(predict_contact(pending_pairs.pop_front()));
      gap_left = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) gap_left = 0;
      if (gap_left == 0 && pending_pairs.size() > 0 && !drain_request) begin
        nx = pending_pairs[0];
        in_opcode <= nx.op;
        in_a_x <= nx.a[0]; in_a_y <= nx.a[1]; in_a_z <= nx.a[2];
        in_b_x <= nx.b[0]; in_b_y <= nx.b[1]; in_b_z <= nx.b[2];
        in_a_radius <= nx.ra; in_b_radius <= nx.rb;
      end else begin
        in_valid <= 1'b0;
      end
    end else if (gap_left > 0) begin
      gap_left--;
    end else if (pending_pairs.size() > 0 && !drain_request) begin
      in_valid <= 1'b1;
      in_opcode <= pending_pairs[0].op;
      in_a_x <= pending_pairs[0].a[0];
      in_a_y <= pending_pairs[0].a[1];
      in_a_z <= pending_pairs[0].a[2];
      in_b_x <= pending_pairs[0].b[0];
      in_b_y <= pending_pairs[0].b[1];
      in_b_z <= pending_pairs[0].b[2];
      in_a_radius <= pending_pairs[0].ra;
      in_b_radius <= pending_pairs[0].rb;
    end
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH result %0d %s: got %0d expected %0d", checked_results, what, got,
             want);
    error_count++;
  endtask

  // Monitor: compares each result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      contact_t e;
      if (expected_contacts.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        e = expected_contacts.pop_front();
        if (out_hit !== e.hit) report_mismatch("hit", out_hit, e.hit);
        if (out_dir_x !== e.dir[0]) report_mismatch("dir_x", out_dir_x, e.dir[0]);
        if (out_dir_y !== e.dir[1]) report_mismatch("dir_y", out_dir_y, e.dir[1]);
        if (out_dir_z !== e.dir[2]) report_mismatch("dir_z", out_dir_z, e.dir[2]);
        if (out_near_x !== e.near[0]) report_mismatch("near_x", out_near_x, e.near[0]);
        if (out_near_y !== e.near[1]) report_mismatch("near_y", out_near_y, e.near[1]);
        if (out_near_z !== e.near[2]) report_mismatch("near_z", out_near_z, e.near[2]);
        if (e.hit) hit_count++;
      end
      checked_results++;
    end
  end

  // Receiver stall: random per result, plus one long hold-off.
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (hold_request && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= hold_left > 1;
    end else if (out_valid && !out_stall) begin
      stall_left = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) stall_left = 0;
      out_stall <= stall_left > 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= stall_left > 0;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout waiting for the block");
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // End of run.
  initial begin
    wait (gen_done);
    wait (pending_pairs.size() == 0 && !in_valid && expected_contacts.size() == 0);
    repeat (LATENCY + 5) @(posedge clk);
    $display("Sent %0d and checked %0d shape pairs over all four pair kinds (%0d hits)",
             accepted_pairs, checked_results, hit_count);
    $display("under random gaps, stalls, one long output hold and one full drain.");
    if (error_count == 0 && expected_contacts.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/sbc_pkg.sv
hdl/sbc_front.sv
hdl/sbc_lane.sv
hdl/sbc_merge.sv
hdl/sphere_box_collision_test.sv
hdl/sbc_checker.sv
bench/tb_sphere_box_collision_test.sv
